/* src/bqc_pkg.sv */
`default_nettype none

package bqc_pkg;

  // Fixed-point format of the coefficients and depth of the rotation chain
  localparam int COEF_FRAC_BITS = 28;
  localparam int TAN_ITERATIONS = 24;

  // Steps of each digit-recurrence chain
  localparam int F_STEPS    = 32;
  localparam int PQ_STEPS   = 58;
  localparam int NORM_STEPS = 5;
  localparam int COEF_STEPS = COEF_FRAC_BITS + 2;
  localparam int NUM_W      = COEF_FRAC_BITS + 34;

  localparam int CORDIC_W = 34;
  localparam int CS_W     = 27;
  localparam int TERM_W   = 58;
  localparam int TOT_W    = 59;
  localparam int REM_W    = 32;
  localparam int WORK_W   = 64;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
  } cordic_t;

  // Partial remainder, divisor, and a word that shifts dividend bits out of
  // the top while quotient bits shift in at the bottom
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [REM_W-1:0]  den;
    logic [WORK_W-1:0] work;
  } div_t;

  typedef struct packed {
    logic [TOT_W-1:0]  tot;
    logic [TERM_W-1:0] cc;
    logic [TERM_W-1:0] ss;
    logic [TERM_W-1:0] pq;
  } norm_t;

endpackage

`default_nettype wire

/* src/biquad_coefficient_calculator_unit.sv */
`default_nettype none

// Biquad coefficient calculator: takes a filter type, a cutoff in Hz and a Q in
// unsigned Q8.8 and returns b0, b1, b2, a1, a2 in signed Q3.28 for a
// bilinear-transform lowpass, highpass or bandpass (type 3 is lowpass). The
// cutoff is clamped to floor(0.499 * sample rate) and Q to at least 26/256.
// One request is taken every clock cycle while no stall holds the pipeline.
// It is built from cell chains: a 32-step divider for the normalised
// frequency, a 24-step CORDIC rotation, a 58-step divider by Q, a 5-step
// normalising shifter and three parallel 30-step coefficient dividers, plus
// nine plain pipeline registers. A stall on the result side halts the whole
// pipeline. The sample rate register resets to 48000; the user must write it
// only while no request is in flight, as the block itself does not enforce this.
module biquad_coefficient_calculator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_rate_wr_en,
  input  logic [17:0]        sample_rate_hz,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         filter_type,
  input  logic [16:0]        cutoff_freq_hz,
  input  logic [15:0]        quality_q88,
  output logic               coef_valid,
  input  logic               coef_stall,
  output logic signed [31:0] coef_b0,
  output logic signed [31:0] coef_b1,
  output logic signed [31:0] coef_b2,
  output logic signed [31:0] coef_a1,
  output logic signed [31:0] coef_a2
);
  import bqc_pkg::*;

  localparam logic [1:0]  TYPE_HIGHPASS = 2'd1;
  localparam logic [1:0]  TYPE_BANDPASS = 2'd2;
  localparam logic [17:0] FS_RESET      = 18'd48000;
  localparam logic [15:0] Q_MIN         = 16'd26;
  localparam logic [31:0] PI_Q30        = 32'd3373259426;
  localparam logic [27:0] LIM_MUL       = 28'd137438954;
  localparam int          LIM_SHIFT     = 37;

  localparam int LV_S3   = 3;
  localparam int LV_MUL  = LV_S3 + F_STEPS + 1 + TAN_ITERATIONS + 2;
  localparam int LV_PQ   = LV_MUL + PQ_STEPS;
  localparam int LV_NORM = LV_PQ + NORM_STEPS;
  localparam int LV_SN   = LV_NORM + 2;
  localparam int LV_CDIV = LV_SN + COEF_STEPS;

  localparam logic signed [33:0] MAX34 = 34'sd2147483647;
  localparam logic signed [33:0] MIN34 = -34'sd2147483648;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > MAX34) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < MIN34) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] apply_sign(input logic [COEF_STEPS-1:0] mag,
                                                    input logic neg);
    logic signed [33:0] m;
    m = $signed(34'(mag));
    return sat34(neg ? -m : m);
  endfunction

  logic        adv;
  logic [17:0] fs_reg;

  logic        vld_pipe [LV_CDIV];
  logic [1:0]  ty_pipe  [LV_NORM];
  logic [15:0] q_pipe   [LV_MUL];
  logic [53:0] cc_pipe  [PQ_STEPS];
  logic [53:0] ss_pipe  [PQ_STEPS];

  logic [16:0] s1_cut, s2_cut, s3_cut;
  logic [17:0] s1_fs, s2_fs, s2_lim, s3_den;
  logic [26:0] s1_v;
  logic [54:0] lim_prod;

  div_t        fdiv [F_STEPS+1];
  logic [63:0] th_prod;
  logic [31:0] theta;

  cordic_t         cor [TAN_ITERATIONS+1];
  logic [CS_W-1:0] cs_c, cs_s;
  logic [53:0]     mul_cc, mul_ss, mul_sc;

  div_t  pqd [PQ_STEPS+1];
  norm_t nm  [NORM_STEPS+1];

  logic [31:0] n_cc, n_ss, n_pq, n_sum;
  logic [32:0] n_cs;
  logic [31:0] sd_den, sd_b0mag;
  logic [32:0] sd_a1mag, sd_a2mag;
  logic        sd_a1neg, sd_a2neg;
  logic [1:0]  sd_ty;

  logic [31:0]      sn_den;
  logic [NUM_W-1:0] sn_a1, sn_a2, sn_b0;

  div_t cda1 [COEF_STEPS+1];
  div_t cda2 [COEF_STEPS+1];
  div_t cdb0 [COEF_STEPS+1];

  logic [1:0] tail_ty    [COEF_STEPS+1];
  logic       tail_a1neg [COEF_STEPS+1];
  logic       tail_a2neg [COEF_STEPS+1];

  logic [COEF_STEPS-1:0] qa1, qa2, qb0;
  logic signed [31:0]    b0_v, b1_v, b2_v;
  logic signed [33:0]    b0_x;

  // Pipeline advances whenever the output register is free or being emptied
  assign adv       = !coef_valid || !coef_stall;
  assign req_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fs_reg <= FS_RESET;
    end else if (sample_rate_wr_en) begin
      fs_reg <= sample_rate_hz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LV_CDIV; k++) begin
        vld_pipe[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_pipe[0] <= req_valid;
      for (int k = 1; k < LV_CDIV; k++) begin
        vld_pipe[k] <= vld_pipe[k-1];
      end
    end
  end

  // Side data riding alongside the cell chains
  always_ff @(posedge clk) begin
    if (adv) begin
      ty_pipe[0] <= filter_type;
      for (int k = 1; k < LV_NORM; k++) begin
        ty_pipe[k] <= ty_pipe[k-1];
      end
      q_pipe[0] <= (quality_q88 < Q_MIN) ? Q_MIN : quality_q88;
      for (int k = 1; k < LV_MUL; k++) begin
        q_pipe[k] <= q_pipe[k-1];
      end
      cc_pipe[0] <= mul_cc;
      ss_pipe[0] <= mul_ss;
      for (int k = 1; k < PQ_STEPS; k++) begin
        cc_pipe[k] <= cc_pipe[k-1];
        ss_pipe[k] <= ss_pipe[k-1];
      end
    end
  end

  // Cutoff limit: floor(fs * 499 / 1000) by reciprocal multiply
  assign lim_prod = 55'(s1_v) * 55'(LIM_MUL);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cut <= cutoff_freq_hz;
      s1_fs  <= fs_reg;
      s1_v   <= 27'(fs_reg) * 27'd499;
      s2_cut <= s1_cut;
      s2_fs  <= s1_fs;
      s2_lim <= lim_prod[LIM_SHIFT +: 18];
      s3_cut <= (18'(s2_cut) > s2_lim) ? s2_lim[16:0] : s2_cut;
      // a zero rate leaves a zero cutoff; a unit divisor then gives a zero phase
      s3_den <= (s2_fs == '0) ? 18'd1 : s2_fs;
    end
  end

  assign fdiv[0] = '{rem: REM_W'(s3_cut), den: REM_W'(s3_den), work: '0};

  for (genvar k = 0; k < F_STEPS; k++) begin : g_fdiv
    bqc_div_cell u_cell (.clk(clk), .en(adv), .d(fdiv[k]), .q(fdiv[k+1]));
  end

  assign th_prod = 64'(fdiv[F_STEPS].work[31:0]) * 64'(PI_Q30);

  always_ff @(posedge clk) begin
    if (adv) begin
      theta <= th_prod[63:32];
    end
  end

  assign cor[0] = '{x: CORDIC_W'(32'h4000_0000), y: '0, z: {2'b00, theta}};

  for (genvar k = 0; k < TAN_ITERATIONS; k++) begin : g_cordic
    bqc_cordic_cell u_cell (
      .clk(clk), .en(adv), .step(5'(k)), .d(cor[k]), .q(cor[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs_c   <= cor[TAN_ITERATIONS].x[CORDIC_W-1] ? '0 : cor[TAN_ITERATIONS].x[30:4];
      cs_s   <= cor[TAN_ITERATIONS].y[CORDIC_W-1] ? '0 : cor[TAN_ITERATIONS].y[30:4];
      mul_cc <= 54'(cs_c) * 54'(cs_c);
      mul_ss <= 54'(cs_s) * 54'(cs_s);
      mul_sc <= 54'(cs_s) * 54'(cs_c);
    end
  end

  // pq = (s*c << 8) / q; the top four quotient bits are zero since q >= 26
  assign pqd[0] = '{rem: REM_W'(mul_sc[53:50]), den: REM_W'(q_pipe[LV_MUL-1]),
                    work: {mul_sc[49:0], 14'b0}};

  for (genvar k = 0; k < PQ_STEPS; k++) begin : g_pqdiv
    bqc_div_cell u_cell (.clk(clk), .en(adv), .d(pqd[k]), .q(pqd[k+1]));
  end

  assign nm[0] = '{tot: TOT_W'(cc_pipe[PQ_STEPS-1]) + TOT_W'(ss_pipe[PQ_STEPS-1])
                        + TOT_W'(pqd[PQ_STEPS].work[TERM_W-1:0]),
                   cc:  TERM_W'(cc_pipe[PQ_STEPS-1]),
                   ss:  TERM_W'(ss_pipe[PQ_STEPS-1]),
                   pq:  pqd[PQ_STEPS].work[TERM_W-1:0]};

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    bqc_norm_cell u_cell (
      .clk(clk), .en(adv), .amt(5'(1 << (NORM_STEPS - 1 - k))), .d(nm[k]), .q(nm[k+1])
    );
  end

  assign n_cc  = nm[NORM_STEPS].cc[31:0];
  assign n_ss  = nm[NORM_STEPS].ss[31:0];
  assign n_pq  = nm[NORM_STEPS].pq[31:0];
  assign n_cs  = 33'(n_cc) + 33'(n_ss);
  // denominator is the sum of the shifted terms, not the shifted total
  assign n_sum = 32'(n_cs + 33'(n_pq));

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_den <= (n_sum == '0) ? 32'd1 : n_sum;
      if (n_ss >= n_cc) begin
        sd_a1mag <= {n_ss - n_cc, 1'b0};
        sd_a1neg <= 1'b0;
      end else begin
        sd_a1mag <= {n_cc - n_ss, 1'b0};
        sd_a1neg <= 1'b1;
      end
      if (n_cs >= 33'(n_pq)) begin
        sd_a2mag <= n_cs - 33'(n_pq);
        sd_a2neg <= 1'b0;
      end else begin
        sd_a2mag <= 33'(n_pq) - n_cs;
        sd_a2neg <= 1'b1;
      end
      unique case (ty_pipe[LV_NORM-1])
        TYPE_HIGHPASS: sd_b0mag <= n_cc;
        TYPE_BANDPASS: sd_b0mag <= n_pq;
        default:       sd_b0mag <= n_ss;
      endcase
      sd_ty <= ty_pipe[LV_NORM-1];

      // dividend for round-half-up: mag << frac + den / 2
      sn_den <= sd_den;
      sn_a1  <= NUM_W'({sd_a1mag, {COEF_FRAC_BITS{1'b0}}}) + NUM_W'(sd_den >> 1);
      sn_a2  <= NUM_W'({sd_a2mag, {COEF_FRAC_BITS{1'b0}}}) + NUM_W'(sd_den >> 1);
      sn_b0  <= NUM_W'({sd_b0mag, {COEF_FRAC_BITS{1'b0}}}) + NUM_W'(sd_den >> 1);

      tail_ty[0]    <= sd_ty;
      tail_a1neg[0] <= sd_a1neg;
      tail_a2neg[0] <= sd_a2neg;
      for (int k = 1; k <= COEF_STEPS; k++) begin
        tail_ty[k]    <= tail_ty[k-1];
        tail_a1neg[k] <= tail_a1neg[k-1];
        tail_a2neg[k] <= tail_a2neg[k-1];
      end
    end
  end

  assign cda1[0] = '{rem: sn_a1[NUM_W-1:COEF_STEPS], den: sn_den,
                     work: {sn_a1[COEF_STEPS-1:0], {(WORK_W-COEF_STEPS){1'b0}}}};
  assign cda2[0] = '{rem: sn_a2[NUM_W-1:COEF_STEPS], den: sn_den,
                     work: {sn_a2[COEF_STEPS-1:0], {(WORK_W-COEF_STEPS){1'b0}}}};
  assign cdb0[0] = '{rem: sn_b0[NUM_W-1:COEF_STEPS], den: sn_den,
                     work: {sn_b0[COEF_STEPS-1:0], {(WORK_W-COEF_STEPS){1'b0}}}};

  for (genvar k = 0; k < COEF_STEPS; k++) begin : g_cdiv
    bqc_div_cell u_a1 (.clk(clk), .en(adv), .d(cda1[k]), .q(cda1[k+1]));
    bqc_div_cell u_a2 (.clk(clk), .en(adv), .d(cda2[k]), .q(cda2[k+1]));
    bqc_div_cell u_b0 (.clk(clk), .en(adv), .d(cdb0[k]), .q(cdb0[k+1]));
  end

  assign qa1 = cda1[COEF_STEPS].work[COEF_STEPS-1:0];
  assign qa2 = cda2[COEF_STEPS].work[COEF_STEPS-1:0];
  assign qb0 = cdb0[COEF_STEPS].work[COEF_STEPS-1:0];

  always_comb begin
    b0_v = apply_sign(qb0, 1'b0);
    b0_x = {{2{b0_v[31]}}, b0_v};
    unique case (tail_ty[COEF_STEPS])
      TYPE_HIGHPASS: begin
        b1_v = sat34(-(b0_x <<< 1));
        b2_v = b0_v;
      end
      TYPE_BANDPASS: begin
        b1_v = '0;
        b2_v = sat34(-b0_x);
      end
      default: begin
        b1_v = sat34(b0_x <<< 1);
        b2_v = b0_v;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_valid <= 1'b0;
    end else if (adv) begin
      coef_valid <= vld_pipe[LV_CDIV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      coef_b0 <= b0_v;
      coef_b1 <= b1_v;
      coef_b2 <= b2_v;
      coef_a1 <= apply_sign(qa1, tail_a1neg[COEF_STEPS]);
      coef_a2 <= apply_sign(qa2, tail_a2neg[COEF_STEPS]);
    end
  end

`ifndef SYNTHESIS
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    coef_valid && coef_stall |-> req_stall)
    else $error("input accepted while result beat held");

  a_rst_empty: assert property (@(posedge clk) rst |=> !coef_valid)
    else $error("result valid straight after reset");

  a_fdiv_range: assert property (@(posedge clk) disable iff (rst)
    vld_pipe[LV_S3-1] |-> fdiv[0].rem < fdiv[0].den)
    else $error("clamped cutoff not below divisor");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    vld_pipe[LV_SN-1] |-> sn_den != '0)
    else $error("zero coefficient denominator");

  a_b0_unit: assert property (@(posedge clk) disable iff (rst)
    vld_pipe[LV_CDIV-1] |-> qb0 <= (COEF_STEPS'(1) << COEF_FRAC_BITS))
    else $error("b0 magnitude above one");
`endif

endmodule

`default_nettype wire

/* src/bqc_cordic_cell.sv */
`default_nettype none

module bqc_cordic_cell (
  input  logic            clk,
  input  logic            en,
  input  logic [4:0]      step,
  input  bqc_pkg::cordic_t d,
  output bqc_pkg::cordic_t q
);
  import bqc_pkg::*;

  logic signed [CORDIC_W-1:0] xi, yi, xs, ys, at;
  cordic_t nxt;

  always_comb begin
    xi = d.x;
    yi = d.y;
    xs = xi >>> step;
    ys = yi >>> step;
    at = {2'b00, ATAN_Q30[step]};
    // rotate towards zero residual angle
    if (!d.z[CORDIC_W-1]) begin
      nxt.x = xi - ys;
      nxt.y = yi + xs;
      nxt.z = d.z - at;
    end else begin
      nxt.x = xi + ys;
      nxt.y = yi - xs;
      nxt.z = d.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

`default_nettype wire

/* src/bqc_div_cell.sv */
`default_nettype none

module bqc_div_cell (
  input  logic          clk,
  input  logic          en,
  input  bqc_pkg::div_t d,
  output bqc_pkg::div_t q
);
  import bqc_pkg::*;

  logic [REM_W:0] trial, diff;
  logic           ge;
  div_t           nxt;

  always_comb begin
    trial    = {d.rem, d.work[WORK_W-1]};
    diff     = trial - {1'b0, d.den};
    ge       = trial >= {1'b0, d.den};
    nxt.rem  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    nxt.den  = d.den;
    nxt.work = {d.work[WORK_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

`default_nettype wire

/* src/bqc_norm_cell.sv */
`default_nettype none

module bqc_norm_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [4:0]     amt,
  input  bqc_pkg::norm_t d,
  output bqc_pkg::norm_t q
);
  import bqc_pkg::*;

  logic  hit;
  norm_t nxt;

  always_comb begin
    // shift when the total still has bits at or above 2^(31+amt)
    hit = (d.tot >> ({1'b0, amt} + 6'd31)) != '0;
    if (hit) begin
      nxt.tot = d.tot >> amt;
      nxt.cc  = d.cc >> amt;
      nxt.ss  = d.ss >> amt;
      nxt.pq  = d.pq >> amt;
    end else begin
      nxt = d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

`default_nettype wire
